>>> rtl/nfba_pkg.sv
`timescale 1ns / 1ps

package nfba_pkg;

  // Table geometry
  localparam int MAX_BLOCKS = 32;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Field widths of the ports
  localparam int BLK_IDX_W = 5;
  localparam int SIZE_W    = 16;
  localparam int CFG_W     = 6;
  localparam int TOT_W     = 21;

  // Block count after reset
  localparam int BLOCK_COUNT_RST = 32;

  // Totals saturate here
  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  // Raw free-size sum holds every block at full size without wrapping
  localparam int SUM_W = SIZE_BITS + CNT_W;

  // Request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // Request as classified by the front end
  typedef struct packed {
    logic                 is_alloc;
    logic                 load_ok;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
  } item_t;

  // One result
  typedef struct packed {
    logic                 granted;
    logic [IDX_W-1:0]     block_number;
    logic [SIZE_BITS-1:0] leftover;
    logic [TOT_W-1:0]     internal_total;
    logic [TOT_W-1:0]     external_total;
  } res_t;

endpackage

>>> rtl/nfba_ram.sv
`timescale 1ns / 1ps

module nfba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/nfba_front.sv
`timescale 1ns / 1ps

module nfba_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [nfba_pkg::BLK_IDX_W-1:0] in_block_index,
  input  logic [nfba_pkg::SIZE_W-1:0]    in_size,
  output logic                          q_valid,
  output nfba_pkg::item_t               q_item,
  input  logic                          q_pop
);

  nfba_pkg::item_t entry_r [2];
  nfba_pkg::item_t item_in;
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            push;
  logic            pop;

  // Classify the incoming request
  always_comb begin
    item_in          = '0;
    item_in.is_alloc = (in_req_type == nfba_pkg::REQ_ALLOC);
    item_in.load_ok  = (32'(in_block_index) < nfba_pkg::MAX_BLOCKS);
    item_in.idx      = nfba_pkg::IDX_W'(in_block_index);
    item_in.size     = nfba_pkg::SIZE_BITS'(in_size);
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = entry_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

>>> rtl/nfba_back.sv
`timescale 1ns / 1ps

module nfba_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [nfba_pkg::CNT_W-1:0]  eff_count,
  input  logic                        q_valid,
  input  nfba_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output nfba_pkg::res_t              out_res
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRAP  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                             state_r, state_nxt;
  nfba_pkg::item_t                    item_r, item_nxt;
  logic [nfba_pkg::MAX_BLOCKS-1:0]    taken_r, taken_nxt;
  logic [nfba_pkg::IDX_W-1:0]         rove_r, rove_nxt;
  logic [nfba_pkg::TOT_W-1:0]         internal_r, internal_nxt;
  logic [nfba_pkg::IDX_W-1:0]         j_r, j_nxt;
  logic [nfba_pkg::CNT_W-1:0]         k_r, k_nxt;
  logic                               rd_vld_r, rd_vld_nxt;
  logic                               rd_taken_r, rd_taken_nxt;
  logic [nfba_pkg::IDX_W-1:0]         rd_j_r, rd_j_nxt;
  logic [nfba_pkg::SUM_W-1:0]         sum_r, sum_nxt;
  logic                               found_r, found_nxt;
  logic [nfba_pkg::IDX_W-1:0]         gidx_r, gidx_nxt;
  logic [nfba_pkg::SIZE_BITS-1:0]     gsize_r, gsize_nxt;
  logic                               out_valid_r, out_valid_nxt;
  nfba_pkg::res_t                     res_r, res_nxt;

  logic                               ram_we;
  logic [nfba_pkg::SIZE_BITS-1:0]     ram_rdata;
  logic                               fits;
  logic [nfba_pkg::CNT_W-1:0]         j_inc;
  logic [nfba_pkg::CNT_W-1:0]         g_inc;
  logic [nfba_pkg::SIZE_BITS-1:0]     left;
  logic [nfba_pkg::TOT_W:0]           int_sum;
  logic [nfba_pkg::SUM_W-1:0]         ext_raw;
  logic                               out_free;

  // Block size table
  nfba_ram #(
    .WIDTH (nfba_pkg::SIZE_BITS),
    .DEPTH (nfba_pkg::MAX_BLOCKS)
  ) u_sizes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_item.idx),
    .wdata (q_item.size),
    .raddr (j_r),
    .rdata (ram_rdata)
  );

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign ram_we   = q_pop && !q_item.is_alloc && q_item.load_ok;
  assign j_inc    = nfba_pkg::CNT_W'(j_r) + 1'b1;
  assign g_inc    = nfba_pkg::CNT_W'(gidx_r) + 1'b1;
  assign out_free = !out_valid_r || out_ready;

  // First free block that holds the request
  assign fits = rd_vld_r && item_r.is_alloc && !found_r && !rd_taken_r &&
                (ram_rdata >= item_r.size);

  // Grant arithmetic for the finishing step
  assign left    = found_r ? (gsize_r - item_r.size) : '0;
  assign int_sum = {1'b0, internal_r} + (nfba_pkg::TOT_W + 1)'(left);
  assign ext_raw = sum_r - (found_r ? nfba_pkg::SUM_W'(gsize_r) : '0);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    taken_nxt     = taken_r;
    rove_nxt      = rove_r;
    internal_nxt  = internal_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    rd_vld_nxt    = 1'b0;
    rd_taken_nxt  = taken_r[j_r];
    rd_j_nxt      = j_r;
    sum_nxt       = sum_r;
    found_nxt     = found_r;
    gidx_nxt      = gidx_r;
    gsize_nxt     = gsize_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;

    // Accumulate free sizes and catch the first fit as data returns
    if (rd_vld_r) begin
      if (!rd_taken_r) begin
        sum_nxt = sum_r + nfba_pkg::SUM_W'(ram_rdata);
      end
      if (fits) begin
        found_nxt = 1'b1;
        gidx_nxt  = rd_j_r;
        gsize_nxt = ram_rdata;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          item_nxt  = q_item;
          sum_nxt   = '0;
          found_nxt = 1'b0;
          k_nxt     = '0;
          if (q_item.is_alloc) begin
            j_nxt = rove_r;
            if (nfba_pkg::CNT_W'(rove_r) >= eff_count) begin
              state_nxt = S_WRAP;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            j_nxt = '0;
            if (q_item.load_ok) begin
              taken_nxt[q_item.idx] = 1'b0;
            end
            state_nxt = S_SCAN;
          end
        end
      end
      S_WRAP: begin
        // Fold the pointer back below the count, one subtract a cycle
        if (nfba_pkg::CNT_W'(j_r) >= eff_count) begin
          j_nxt = nfba_pkg::IDX_W'(nfba_pkg::CNT_W'(j_r) - eff_count);
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one table read a cycle, circularly
        rd_vld_nxt = 1'b1;
        j_nxt      = (j_inc == eff_count) ? '0 : nfba_pkg::IDX_W'(j_inc);
        k_nxt      = k_r + 1'b1;
        if ((k_r + 1'b1) == eff_count) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          res_nxt.granted        = found_r;
          res_nxt.block_number   = found_r ? gidx_r : '0;
          res_nxt.leftover       = left;
          res_nxt.external_total = (ext_raw > nfba_pkg::SUM_W'(nfba_pkg::TOTAL_MAX)) ?
                                   nfba_pkg::TOTAL_MAX : nfba_pkg::TOT_W'(ext_raw);
          res_nxt.internal_total = internal_r;
          if (found_r) begin
            taken_nxt[gidx_r] = 1'b1;
            rove_nxt          = (g_inc == eff_count) ? '0 : nfba_pkg::IDX_W'(g_inc);
            internal_nxt      = (int_sum > (nfba_pkg::TOT_W + 1)'(nfba_pkg::TOTAL_MAX)) ?
                                nfba_pkg::TOTAL_MAX : nfba_pkg::TOT_W'(int_sum);
            res_nxt.internal_total = internal_nxt;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      taken_r     <= '0;
      rove_r      <= '0;
      internal_r  <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      taken_r     <= taken_nxt;
      rove_r      <= rove_nxt;
      internal_r  <= internal_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    j_r        <= j_nxt;
    rd_taken_r <= rd_taken_nxt;
    rd_j_r     <= rd_j_nxt;
    sum_r      <= sum_nxt;
    gidx_r     <= gidx_nxt;
    gsize_r    <= gsize_nxt;
    res_r      <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // A recorded grant always covers the request
  a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (gsize_r >= item_r.size))
    else $error("granted block smaller than request");

  // Read data only returns right after a scan issue
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ($past(state_r) == S_SCAN))
    else $error("table read outside the scan");

  // The scan never issues more reads than the block count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r < eff_count))
    else $error("scan ran past the block count");

  // A refused or load result carries no block and no leftover
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.granted) |-> (res_r.block_number == '0 && res_r.leftover == '0))
    else $error("ungranted result with block data");

endmodule

>>> rtl/next_fit_block_allocator.sv
`timescale 1ns / 1ps

// Next-fit block allocator. Requests enter a two-deep queue and are carried
// out one at a time by a scan engine that walks the block size table through
// a single registered read port, one block per cycle. Every request, load or
// allocate, walks all n = effective block count blocks (the block count
// register, with 0 acting as 1 and values above 32 acting as 32), so that the
// free-size total can be rebuilt in the same pass; in the engine a request
// passes through the idle, scan, drain and done states. After the block
// count has been lowered below the roving pointer, the next allocate first
// folds the pointer back into range in the wrap state. A finished result
// waits in an output register while the queue keeps taking requests until
// it is full. Write the block count only while no request is outstanding.
module next_fit_block_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [nfba_pkg::BLK_IDX_W-1:0] in_block_index,
  input  logic [nfba_pkg::SIZE_W-1:0]    in_size,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_granted,
  output logic [nfba_pkg::BLK_IDX_W-1:0] out_block_number,
  output logic [nfba_pkg::SIZE_W-1:0]    out_leftover,
  output logic [nfba_pkg::TOT_W-1:0]     out_internal_total,
  output logic [nfba_pkg::TOT_W-1:0]     out_external_total,
  input  logic                           cfg_we,
  input  logic [nfba_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [nfba_pkg::CFG_W-1:0] block_count_r;
  logic [nfba_pkg::CFG_W-1:0] block_count_nxt;
  logic [nfba_pkg::CNT_W-1:0] eff_count;
  logic                       q_valid;
  nfba_pkg::item_t            q_item;
  logic                       q_pop;
  nfba_pkg::res_t             res;

  // Block count register
  assign block_count_nxt = cfg_we ? cfg_wdata : block_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= nfba_pkg::CFG_W'(nfba_pkg::BLOCK_COUNT_RST);
    end else begin
      block_count_r <= block_count_nxt;
    end
  end

  // Clamp the count into the table
  always_comb begin
    if (block_count_r == '0) begin
      eff_count = nfba_pkg::CNT_W'(1);
    end else if (32'(block_count_r) > nfba_pkg::MAX_BLOCKS) begin
      eff_count = nfba_pkg::CNT_W'(nfba_pkg::MAX_BLOCKS);
    end else begin
      eff_count = nfba_pkg::CNT_W'(block_count_r);
    end
  end

  nfba_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_block_index (in_block_index),
    .in_size        (in_size),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  nfba_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_count (eff_count),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Unpack the result
  assign out_granted        = res.granted;
  assign out_block_number   = nfba_pkg::BLK_IDX_W'(res.block_number);
  assign out_leftover       = nfba_pkg::SIZE_W'(res.leftover);
  assign out_internal_total = res.internal_total;
  assign out_external_total = res.external_total;

endmodule
